// File: src/fac_pkg.sv
// fac_pkg: shared constants and types of the frustum/box cull test
// depends on nothing; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package fac_pkg;

    localparam int NumPlanes = 6;                  // planes tested per box
    localparam int CfgCount  = 6;                  // planes that have a register
    localparam int CfgIdxW   = $clog2(CfgCount);   // register index width
    localparam int CoordW    = 16;                 // Q12.4 coordinates, Q1.14 normals
    localparam int PlaneW    = 4 * CoordW;         // packed plane register
    localparam int ProdW     = 2 * CoordW;         // exact normal * coordinate
    localparam int FracShift = 14;                 // Q12.4 distance to Q.18
    localparam int DqW       = CoordW + FracShift;
    localparam int DistW     = ProdW + 3;          // three products plus distance
    localparam int NumTerms  = 6;                  // products per plane
    localparam int VerdictW  = 2;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic signed [DqW-1:0]    t_dq;
    typedef logic signed [DistW-1:0]  t_dist;

    typedef struct packed {
        t_coord d;
        t_coord nz;
        t_coord ny;
        t_coord nx;
    } t_plane;

    typedef enum logic [VerdictW-1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } t_verdict;

endpackage

// File: src/fac_box_if.sv
// fac_box_if: valid/ready channel carrying one box word (min and max corners)
// depends on fac_pkg
`timescale 1ns / 1ps

interface fac_box_if;
    logic           valid;
    logic           ready;
    fac_pkg::t_coord min_x;
    fac_pkg::t_coord min_y;
    fac_pkg::t_coord min_z;
    fac_pkg::t_coord max_x;
    fac_pkg::t_coord max_y;
    fac_pkg::t_coord max_z;

    modport source (output valid, output min_x, output min_y, output min_z,
                    output max_x, output max_y, output max_z, input ready);
    modport sink   (input valid, input min_x, input min_y, input min_z,
                    input max_x, input max_y, input max_z, output ready);
endinterface

// File: src/fac_verdict_if.sv
// fac_verdict_if: valid/ready channel carrying one verdict word
// depends on fac_pkg
`timescale 1ns / 1ps

interface fac_verdict_if;
    logic                          valid;
    logic                          ready;
    logic [fac_pkg::VerdictW-1:0]  verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// File: src/frustum_aabb_cull_test.sv
// frustum_aabb_cull_test: classifies an axis-aligned box against the frustum planes
// depends on fac_pkg, fac_box_if, fac_verdict_if
`timescale 1ns / 1ps

// Takes one box word per cycle unless stalled and returns one verdict word per box
// (0 inside, 1 intersecting, 2 outside) through the product and verdict registers.
// The first stage registers all normal-times-coordinate products of every plane
// (six 16x16 multipliers per plane); the second stage picks the low and high
// product per axis, sums them with the plane distance and registers the verdict.
// An output stall holds stage 2, and stage 1 once full. The user must write plane
// registers via the config port only while no box is in flight; it is not enforced.
module frustum_aabb_cull_test (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fac_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [fac_pkg::PlaneW-1:0]     i_cfg_data,
    fac_box_if.sink                        i_box,
    fac_verdict_if.source                  o_res
);

    fac_pkg::t_plane   r_plane [fac_pkg::CfgCount];
    fac_pkg::t_plane   w_plane [fac_pkg::NumPlanes];

    logic              r_v1;
    logic              r_v2;
    fac_pkg::t_prod    r_prod [fac_pkg::NumPlanes][fac_pkg::NumTerms];
    fac_pkg::t_prod    n_prod [fac_pkg::NumPlanes][fac_pkg::NumTerms];
    fac_pkg::t_dq      r_dq   [fac_pkg::NumPlanes];
    fac_pkg::t_dq      n_dq   [fac_pkg::NumPlanes];
    fac_pkg::t_verdict r_verdict;
    fac_pkg::t_verdict n_verdict;

    logic [fac_pkg::NumPlanes-1:0] w_out;
    logic [fac_pkg::NumPlanes-1:0] w_part;

    logic w_acc;
    logic w_load2;

    // planes without a register read as zero and pass
    for (genvar p = 0; p < fac_pkg::NumPlanes; p++) begin : g_plane
        if (p < fac_pkg::CfgCount) begin : g_reg
            assign w_plane[p] = r_plane[p];
        end else begin : g_zero
            assign w_plane[p] = '0;
        end
    end

    // handshake
    assign w_load2     = r_v1 && (!r_v2 || o_res.ready);
    assign i_box.ready = !r_v1 || w_load2;
    assign w_acc       = i_box.valid && i_box.ready;
    assign o_res.valid   = r_v2;
    assign o_res.verdict = r_verdict;

    // stage 1: products
    always_comb begin
        for (int p = 0; p < fac_pkg::NumPlanes; p++) begin
            n_prod[p][0] = fac_pkg::ProdW'(w_plane[p].nx) * fac_pkg::ProdW'(i_box.min_x);
            n_prod[p][1] = fac_pkg::ProdW'(w_plane[p].nx) * fac_pkg::ProdW'(i_box.max_x);
            n_prod[p][2] = fac_pkg::ProdW'(w_plane[p].ny) * fac_pkg::ProdW'(i_box.min_y);
            n_prod[p][3] = fac_pkg::ProdW'(w_plane[p].ny) * fac_pkg::ProdW'(i_box.max_y);
            n_prod[p][4] = fac_pkg::ProdW'(w_plane[p].nz) * fac_pkg::ProdW'(i_box.min_z);
            n_prod[p][5] = fac_pkg::ProdW'(w_plane[p].nz) * fac_pkg::ProdW'(i_box.max_z);
            n_dq[p]      = $signed({w_plane[p].d, {fac_pkg::FracShift{1'b0}}});
        end
    end

    // stage 2: per-plane min and max distance, then verdict
    always_comb begin
        fac_pkg::t_prod lo;
        fac_pkg::t_prod hi;
        fac_pkg::t_dist dmin;
        fac_pkg::t_dist dmax;
        for (int p = 0; p < fac_pkg::NumPlanes; p++) begin
            dmin = fac_pkg::DistW'(r_dq[p]);
            dmax = fac_pkg::DistW'(r_dq[p]);
            for (int a = 0; a < fac_pkg::NumTerms / 2; a++) begin
                if (r_prod[p][2*a] < r_prod[p][2*a+1]) begin
                    lo = r_prod[p][2*a];
                    hi = r_prod[p][2*a+1];
                end else begin
                    lo = r_prod[p][2*a+1];
                    hi = r_prod[p][2*a];
                end
                dmin = dmin + fac_pkg::DistW'(lo);
                dmax = dmax + fac_pkg::DistW'(hi);
            end
            w_out[p]  = dmax[fac_pkg::DistW-1];
            w_part[p] = dmin[fac_pkg::DistW-1];
        end
        if (|w_out) begin
            n_verdict = fac_pkg::VERDICT_OUTSIDE;
        end else if (|w_part) begin
            n_verdict = fac_pkg::VERDICT_INTERSECT;
        end else begin
            n_verdict = fac_pkg::VERDICT_INSIDE;
        end
    end

    // control and plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int i = 0; i < fac_pkg::CfgCount; i++) begin
                r_plane[i] <= '0;
            end
        end else begin
            r_v1 <= w_acc || (r_v1 && !w_load2);
            r_v2 <= w_load2 || (r_v2 && !o_res.ready);
            if (i_cfg_we && (i_cfg_idx < fac_pkg::CfgIdxW'(fac_pkg::CfgCount))) begin
                r_plane[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_prod <= n_prod;
            r_dq   <= n_dq;
        end
        if (w_load2) begin
            r_verdict <= n_verdict;
        end
    end

endmodule
